/* design/elevator_disk_request_queue_macros.svh */
// Assertion macros for the elevator disk request queue
`ifndef ELEVATOR_DISK_REQUEST_QUEUE_MACROS_SVH
`define ELEVATOR_DISK_REQUEST_QUEUE_MACROS_SVH
`ifndef SYNTH
`define EDRQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("edrq check failed");
`define EDRQ_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("edrq check failed");
`else
`define EDRQ_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define EDRQ_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* design/edrq_pkg.sv */
// ----------------------------------------------------------------------------
// edrq_pkg
// Types and constants shared by the elevator disk request queue.
// ----------------------------------------------------------------------------
package edrq_pkg;

    localparam int QUEUE_DEPTH_DEF = 32;
    localparam logic [3:0] MAX_ERRORS_RESET = 4'd5;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_DONE   = 2'd1;
    localparam logic [1:0] CMD_ERROR  = 2'd2;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [1:0]  cmd;
        logic        drive;
        logic [15:0] cylinder;
        logic [3:0]  head_index;
        logic [7:0]  sector;
        logic        is_write;
        logic [7:0]  tag;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        finished;
        logic [7:0]  finished_tag;
        logic        finished_ok;
        logic        cur_valid;
        logic        cur_drive;
        logic [15:0] cur_cylinder;
        logic [3:0]  cur_head;
        logic [7:0]  cur_sector;
        logic        cur_write;
        logic [7:0]  cur_tag;
        logic        cur_half;
    } rsp_t;

    // request body kept in a slot
    typedef struct packed {
        logic        drive;
        logic [15:0] cylinder;
        logic [3:0]  head;
        logic [7:0]  sector;
        logic        is_write;
        logic [7:0]  tag;
    } slot_t;

    function automatic logic [28:0] order_key(input slot_t s);
        order_key = {s.drive, s.cylinder, s.head, s.sector};
    endfunction

endpackage

/* design/elevator_disk_request_queue.sv */
// ----------------------------------------------------------------------------
// elevator_disk_request_queue
// Slot pool kept as a linked queue in elevator order, headed by the current
// request.
// ----------------------------------------------------------------------------
// Usage: pulse start with req while busy is low. Insert (cmd 0) puts the
// request into the lowest free slot and links it in elevator order; done and
// error (cmd 1, 2) act on the current request. One result comes back on rsp
// with done high for exactly one cycle; it cannot be held off.
// Done, error, unused commands and a refused insert walk nothing. An insert
// into an empty queue links the new slot as current without a walk; otherwise
// it takes one step for the free-slot search, one read per hop, a read plus a
// compare per entry walked, one or two link writes, then the result read.
// The walk is set by the single read port of the link and slot memories.
// busy stays high through the done cycle, so a new request is taken only
// after the result has come out.
// The error limit register is written over cfg_valid/cfg_ready (ready while
// idle). Reset frees all slots, empties the queue and sets the limit to 5.
// Slot memories need no clearing pass; only the contents of busy slots are ever used.
// ----------------------------------------------------------------------------
`include "elevator_disk_request_queue_macros.svh"

module elevator_disk_request_queue #(
    parameter int QUEUE_DEPTH = edrq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  edrq_pkg::req_t   req,
    output logic             busy,
    output logic             done,
    output edrq_pkg::rsp_t   rsp,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [3:0]       cfg_data
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int PW = AW + 1; // pointer with null flag in msb
    localparam logic [PW-1:0] NIL = {1'b1, {AW{1'b0}}};

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_FIND  = 3'd1;
    localparam logic [2:0] S_RD    = 3'd2; // read t link + fields
    localparam logic [2:0] S_CMP   = 3'd3; // read nx fields, compare
    localparam logic [2:0] S_LINK  = 3'd4;
    localparam logic [2:0] S_OP    = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;
    localparam logic [2:0] S_RESP  = 3'd7;

    // memories: one read port each, registered read data
    logic [PW-1:0]       next_mem [QUEUE_DEPTH];
    edrq_pkg::slot_t     fld_mem  [QUEUE_DEPTH];
    logic [1:0]          rem_mem  [QUEUE_DEPTH];
    logic [7:0]          err_mem  [QUEUE_DEPTH];

    logic [QUEUE_DEPTH-1:0] busy_reg, busy_next;
    logic [2:0]    state_reg, state_next;
    logic [PW-1:0] cur_reg, cur_next;
    logic [3:0]    maxerr_reg;
    edrq_pkg::req_t req_reg;
    logic [AW-1:0] new_reg, new_next;
    logic [PW-1:0] t_reg, t_next;
    logic [PW-1:0] nx_reg, nx_next;
    logic [$clog2(QUEUE_DEPTH+1)-1:0] steps_reg, steps_next;
    logic          phase_reg, phase_next; // walk: 0 first hop, 1 looping
    logic          accept;

    // read port
    logic [AW-1:0]   rd_addr;
    logic [PW-1:0]   rd_next;
    edrq_pkg::slot_t rd_fld;
    logic [1:0]      rd_rem;
    logic [7:0]      rd_err;
    // writes
    logic            wn_en;
    logic [AW-1:0]   wn_addr;
    logic [PW-1:0]   wn_data;
    logic            wf_en;
    logic [AW-1:0]   wf_addr;
    logic            wc_en;
    logic [AW-1:0]   wc_addr;
    logic [1:0]      wc_rem;
    logic [7:0]      wc_err;

    edrq_pkg::slot_t t_fld_reg, t_fld_next;
    edrq_pkg::rsp_t  rsp_reg, rsp_next;
    logic            done_reg, done_next;

    assign accept = start && !busy;

    always_ff @(posedge clk)
    begin
        rd_next <= next_mem[rd_addr];
        rd_fld  <= fld_mem[rd_addr];
        rd_rem  <= rem_mem[rd_addr];
        rd_err  <= err_mem[rd_addr];
        if (wn_en)
        begin
            next_mem[wn_addr] <= wn_data;
        end
        if (wf_en)
        begin
            fld_mem[wf_addr] <= '{drive: req_reg.drive, cylinder: req_reg.cylinder,
                                  head: req_reg.head_index, sector: req_reg.sector,
                                  is_write: req_reg.is_write, tag: req_reg.tag};
        end
        if (wc_en)
        begin
            rem_mem[wc_addr] <= wc_rem;
            err_mem[wc_addr] <= wc_err;
        end
    end

    // lowest free slot
    logic          free_any;
    logic [AW-1:0] free_idx;
    always_comb
    begin
        free_any = 1'b0;
        free_idx = '0;
        for (int i = QUEUE_DEPTH - 1; i >= 0; i--)
        begin
            if (!busy_reg[i])
            begin
                free_any = 1'b1;
                free_idx = AW'(i);
            end
        end
    end

    edrq_pkg::slot_t new_fld;
    assign new_fld = '{drive: req_reg.drive, cylinder: req_reg.cylinder,
                       head: req_reg.head_index, sector: req_reg.sector,
                       is_write: req_reg.is_write, tag: req_reg.tag};

    logic [28:0] key_t, key_n, key_nx;
    logic        fits;
    assign key_t  = edrq_pkg::order_key(t_fld_reg);
    assign key_n  = edrq_pkg::order_key(new_fld);
    assign key_nx = edrq_pkg::order_key(rd_fld);
    assign fits   = ((key_t < key_n) || !(key_t < key_nx)) && (key_n < key_nx);

    logic [1:0] rem_dec;
    logic       drop;
    assign rem_dec = (rd_rem != 2'd0) ? rd_rem - 2'd1 : 2'd0;
    assign drop    = rd_err >= {4'd0, maxerr_reg};

    always_comb
    begin
        state_next = state_reg;
        busy_next  = busy_reg;
        cur_next   = cur_reg;
        new_next   = new_reg;
        t_next     = t_reg;
        nx_next    = nx_reg;
        steps_next = steps_reg;
        phase_next = phase_reg;
        t_fld_next = t_fld_reg;
        rsp_next   = rsp_reg;
        done_next  = 1'b0;
        rd_addr    = cur_reg[AW-1:0];
        wn_en      = 1'b0;
        wn_addr    = new_reg;
        wn_data    = NIL;
        wf_en      = 1'b0;
        wf_addr    = new_reg;
        wc_en      = 1'b0;
        wc_addr    = new_reg;
        wc_rem     = 2'd2;
        wc_err     = 8'd0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    rsp_next.status       = edrq_pkg::ST_DONE;
                    rsp_next.finished     = 1'b0;
                    rsp_next.finished_tag = 8'd0;
                    rsp_next.finished_ok  = 1'b0;
                    if (req.cmd == edrq_pkg::CMD_INSERT)
                    begin
                        state_next = S_FIND;
                    end
                    else
                    begin
                        state_next = S_OP;
                    end
                end
            end
            S_FIND:
            begin
                if (!free_any)
                begin
                    rsp_next.status = edrq_pkg::ST_FULL;
                    state_next = S_OUT;
                end
                else
                begin
                    new_next = free_idx;
                    busy_next[free_idx] = 1'b1;
                    wf_en = 1'b1;
                    wf_addr = free_idx;
                    wc_en = 1'b1;
                    wc_addr = free_idx;
                    wn_en = 1'b1;
                    wn_addr = free_idx;
                    wn_data = NIL;
                    if (cur_reg[AW])
                    begin
                        cur_next = {1'b0, free_idx};
                        state_next = S_OUT;
                    end
                    else
                    begin
                        t_next = cur_reg;
                        rd_addr = cur_reg[AW-1:0];
                        phase_next = 1'b0;
                        steps_next = '0;
                        state_next = S_RD;
                    end
                end
            end
            S_RD:
            begin
                // rd_next/rd_fld hold t's link and fields
                t_fld_next = rd_fld;
                nx_next = rd_next;
                if (rd_next[AW])
                begin
                    state_next = S_LINK;
                end
                else if (!phase_reg)
                begin
                    // step past the head entry
                    t_next = rd_next;
                    rd_addr = rd_next[AW-1:0];
                    phase_next = 1'b1;
                    state_next = S_RD;
                end
                else if (steps_reg == ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH))
                begin
                    state_next = S_LINK;
                end
                else
                begin
                    rd_addr = rd_next[AW-1:0];
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                if (fits)
                begin
                    state_next = S_LINK;
                end
                else
                begin
                    t_next = nx_reg;
                    steps_next = steps_reg + 1'b1;
                    rd_addr = nx_reg[AW-1:0];
                    state_next = S_RD;
                end
            end
            S_LINK:
            begin
                // t.next <= n, then n.next <= old t.next (second write skipped when it is null)
                wn_en = 1'b1;
                wn_addr = t_reg[AW-1:0];
                wn_data = {1'b0, new_reg};
                if (nx_reg[AW])
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    nx_next = NIL;
                    t_next = {1'b0, new_reg};
                    // second write next cycle: new.next <= nx
                    wn_addr = new_reg;
                    wn_data = nx_reg;
                    state_next = S_LINK;
                    // write t first, then come back with t = new
                    if (t_reg[AW-1:0] != new_reg || t_reg[AW])
                    begin
                        wn_addr = t_reg[AW-1:0];
                        wn_data = {1'b0, new_reg};
                        nx_next = nx_reg;
                    end
                    else
                    begin
                        state_next = S_OUT;
                    end
                end
                rd_addr = cur_reg[AW-1:0];
            end
            S_OP:
            begin
                // rd_* hold the current entry
                if (cur_reg[AW])
                begin
                    if (req_reg.cmd == edrq_pkg::CMD_DONE
                        || req_reg.cmd == edrq_pkg::CMD_ERROR)
                    begin
                        rsp_next.status = edrq_pkg::ST_EMPTY;
                    end
                    state_next = S_OUT;
                end
                else if (req_reg.cmd == edrq_pkg::CMD_DONE)
                begin
                    wc_en = 1'b1;
                    wc_addr = cur_reg[AW-1:0];
                    wc_rem = rem_dec;
                    wc_err = rd_fld.is_write ? rd_err : 8'd0;
                    if (rem_dec == 2'd0)
                    begin
                        rsp_next.finished = 1'b1;
                        rsp_next.finished_tag = rd_fld.tag;
                        rsp_next.finished_ok = 1'b1;
                        busy_next[cur_reg[AW-1:0]] = 1'b0;
                        cur_next = rd_next[AW] ? NIL : rd_next;
                    end
                    state_next = S_OUT;
                end
                else if (req_reg.cmd == edrq_pkg::CMD_ERROR)
                begin
                    wc_en = 1'b1;
                    wc_addr = cur_reg[AW-1:0];
                    wc_rem = rd_rem;
                    wc_err = (rd_err != 8'hFF) ? rd_err + 8'd1 : rd_err;
                    if (drop)
                    begin
                        rsp_next.finished = 1'b1;
                        rsp_next.finished_tag = rd_fld.tag;
                        busy_next[cur_reg[AW-1:0]] = 1'b0;
                        cur_next = rd_next[AW] ? NIL : rd_next;
                    end
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                // issue the read of current after this item; rd_* hold it in S_RESP
                rd_addr = cur_reg[AW-1:0];
                state_next = S_RESP;
            end
            S_RESP:
            begin
                done_next = 1'b1;
                rsp_next = rsp_reg;
                rsp_next.cur_valid    = !cur_reg[AW];
                rsp_next.cur_drive    = cur_reg[AW] ? 1'b0 : rd_fld.drive;
                rsp_next.cur_cylinder = cur_reg[AW] ? 16'd0 : rd_fld.cylinder;
                rsp_next.cur_head     = cur_reg[AW] ? 4'd0 : rd_fld.head;
                rsp_next.cur_sector   = cur_reg[AW] ? 8'd0 : rd_fld.sector;
                rsp_next.cur_write    = cur_reg[AW] ? 1'b0 : rd_fld.is_write;
                rsp_next.cur_tag      = cur_reg[AW] ? 8'd0 : rd_fld.tag;
                rsp_next.cur_half     = cur_reg[AW] ? 1'b0 : rd_rem[0];
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            busy_reg   <= '0;
            cur_reg    <= NIL;
            maxerr_reg <= edrq_pkg::MAX_ERRORS_RESET;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
            cur_reg   <= cur_next;
            done_reg  <= done_next;
            if (cfg_valid && cfg_ready)
            begin
                maxerr_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && accept)
        begin
            req_reg <= req;
        end
        new_reg   <= new_next;
        t_reg     <= t_next;
        nx_reg    <= nx_next;
        steps_reg <= steps_next;
        phase_reg <= phase_next;
        t_fld_reg <= t_fld_next;
        rsp_reg   <= rsp_next;
    end

    assign busy      = (state_reg != S_IDLE) || done_reg;
    assign done      = done_reg;
    assign rsp       = rsp_reg;
    assign cfg_ready = !busy;

    `EDRQ_ASSERT_IMP(a_done_idle, clk, rst_n, done_reg, state_reg == S_IDLE)
    `EDRQ_ASSERT_NXT(a_start_busy, clk, rst_n, start && !busy, busy)
    `EDRQ_ASSERT_IMP(a_cur_busy, clk, rst_n, !cur_reg[AW], busy_reg[cur_reg[AW-1:0]])
    `EDRQ_ASSERT_NXT(a_full_keeps, clk, rst_n,
        state_reg == S_FIND && !free_any, $stable(busy_reg))

endmodule
